### rtl/core/timer_table_scheduler_macros.svh
// Assertion macros used by the timer table scheduler checker.
`ifndef TIMER_TABLE_SCHEDULER_MACROS_SVH
`define TIMER_TABLE_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table scheduler check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table scheduler check failed");

`endif

### rtl/core/tts_pkg.sv
// Shared types and constants of the timer table scheduler.
package tts_pkg;

  localparam int ID_W = 31;
  localparam int MS_W = 32;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [ID_W-1:0] ID_ALL_ONES = '1;
  localparam logic [ID_W-1:0] ID_ONE      = 31'd1;

  // What a pass over the slot table does with each slot.
  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_CLEAR,
    MODE_TICK,
    MODE_SELECT
  } mode_t;

  typedef struct packed {
    logic      latch;
    logic      create;
    logic      rd_en;
    logic      first;
    logic      load;
    mode_t     mode;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic due_any;
    logic last;
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] ident;
    logic [ID_W-1:0] remaining;
    logic [ID_W-1:0] interval;
    logic            periodic;
  } slot_t;

endpackage

### rtl/core/tts_ctrl.sv
// Sequencer of the timer table scheduler: decodes items and walks the slot table.
module tts_ctrl #(
  parameter int SLOTS = 16,
  parameter int SW    = 4,
  parameter int CW    = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       action,
  output logic             in_stall,
  input  tts_pkg::status_t status,
  output tts_pkg::cmd_t    cmd,
  output logic [SW-1:0]    rd_addr
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_SCAN,
    ST_SELECT,
    ST_EMIT
  } state_t;

  state_t          state;
  tts_pkg::mode_t  mode;
  logic [CW-1:0]   cnt;
  logic            scan_end;

  assign scan_end = (cnt == CW'(SLOTS));
  assign rd_addr  = cnt[SW-1:0];
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mode   = mode;
    case (state)
      ST_IDLE:   cmd.latch  = in_valid;
      ST_CREATE: cmd.create = 1'b1;
      ST_SCAN, ST_SELECT: begin
        cmd.rd_en = !scan_end;
        cmd.first = (cnt == '0);
      end
      ST_EMIT:   cmd.load   = status.out_free;
      default:   cmd        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= tts_pkg::MODE_PLAIN;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            case (action)
              tts_pkg::ACT_CREATE: begin
                state <= ST_CREATE;
                mode  <= tts_pkg::MODE_PLAIN;
              end
              tts_pkg::ACT_CLEAR: begin
                state <= ST_SCAN;
                mode  <= tts_pkg::MODE_CLEAR;
              end
              tts_pkg::ACT_TICK: begin
                state <= ST_SCAN;
                mode  <= tts_pkg::MODE_TICK;
              end
              default: begin
                state <= ST_SCAN;
                mode  <= tts_pkg::MODE_PLAIN;
              end
            endcase
          end
        end
        ST_CREATE: state <= ST_SCAN;
        ST_SCAN: begin
          if (scan_end) begin
            cnt <= '0;
            if (mode == tts_pkg::MODE_TICK && status.due_any) begin
              state <= ST_SELECT;
              mode  <= tts_pkg::MODE_SELECT;
            end else begin
              state <= ST_EMIT;
            end
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_SELECT: begin
          if (scan_end) begin
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_EMIT: begin
          if (status.out_free) begin
            if (status.last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_SELECT;
              cnt   <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/tts_datapath.sv
// Slot table memory, valid and due flags, scan accumulators and result register.
module tts_datapath #(
  parameter int SLOTS = 16,
  parameter int SW    = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tts_pkg::cmd_t                 cmd,
  input  logic [SW-1:0]                 rd_addr,
  input  logic signed [tts_pkg::MS_W-1:0] delay_ms,
  input  logic                          repeating,
  input  logic [tts_pkg::ID_W-1:0]      timer_id,
  input  logic                          out_stall,
  output tts_pkg::status_t              status,
  output logic                          out_valid,
  output logic [tts_pkg::ID_W-1:0]      assigned_id,
  output logic                          fired,
  output logic [tts_pkg::ID_W-1:0]      fired_id,
  output logic                          last,
  output logic signed [tts_pkg::MS_W-1:0] ms_to_next,
  output logic                          any_active
);

  tts_pkg::slot_t               mem [SLOTS];
  tts_pkg::slot_t               rd_data;
  tts_pkg::slot_t               wr_data;
  logic                         wr_en;
  logic [SW-1:0]                wr_addr;
  logic                         proc_valid;
  logic [SW-1:0]                proc_addr;

  logic [SLOTS-1:0]             valid, valid_next;
  logic [SLOTS-1:0]             due, due_next, due_left;

  logic [tts_pkg::ID_W-1:0]     next_ident, aid, arg_delay, arg_id;
  logic                         arg_rep;

  logic [tts_pkg::ID_W-1:0]     least, best;
  logic                         any, found;
  logic [SW-1:0]                best_slot;

  logic [SW-1:0]                free_slot;
  logic                         free_any;

  logic                         pv, due_hit, keep, select_hit, sel_found;
  logic [tts_pkg::ID_W-1:0]     rem_dec, new_rem, eff_rem;

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_slot = SW'(i);
    end
  end
  assign free_any = ~&valid;

  // Per-slot work on the registered read data
  always_comb begin
    pv      = valid[proc_addr];
    rem_dec = (rd_data.remaining == '0) ? '0 : rd_data.remaining - tts_pkg::ID_ONE;
    due_hit = pv && (rem_dec == '0);
    new_rem = (due_hit && rd_data.periodic) ? rd_data.interval : rem_dec;
    case (cmd.mode)
      tts_pkg::MODE_TICK: begin
        keep    = pv && !(due_hit && !rd_data.periodic);
        eff_rem = new_rem;
      end
      tts_pkg::MODE_CLEAR: begin
        keep    = pv && (rd_data.ident != arg_id);
        eff_rem = rd_data.remaining;
      end
      default: begin
        keep    = pv;
        eff_rem = rd_data.remaining;
      end
    endcase
    select_hit = due[proc_addr] && (!found || (rd_data.ident < best));
    sel_found  = (cmd.mode == tts_pkg::MODE_SELECT) && found;
  end

  // Memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_addr;
    wr_data = rd_data;
    if (cmd.create && free_any) begin
      wr_en             = 1'b1;
      wr_addr           = free_slot;
      wr_data.ident     = next_ident;
      wr_data.remaining = arg_delay;
      wr_data.interval  = arg_delay;
      wr_data.periodic  = arg_rep;
    end else if (proc_valid && cmd.mode == tts_pkg::MODE_TICK && pv) begin
      wr_en             = 1'b1;
      wr_data.remaining = new_rem;
    end
  end

  always_comb begin
    valid_next = valid;
    if (cmd.create && free_any) valid_next[free_slot] = 1'b1;
    if (proc_valid && pv && !keep &&
        (cmd.mode == tts_pkg::MODE_TICK || cmd.mode == tts_pkg::MODE_CLEAR)) begin
      valid_next[proc_addr] = 1'b0;
    end
  end

  always_comb begin
    due_next = due;
    if (cmd.first && cmd.mode == tts_pkg::MODE_TICK) due_next = '0;
    if (proc_valid && cmd.mode == tts_pkg::MODE_TICK && due_hit) due_next[proc_addr] = 1'b1;
    if (cmd.load && sel_found) due_next[best_slot] = 1'b0;
  end

  always_comb begin
    due_left            = due;
    due_left[best_slot] = 1'b0;
  end

  assign status.out_free = !out_valid || !out_stall;
  assign status.due_any  = |due_next;
  assign status.last     = !sel_found || (due_left == '0);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
    proc_addr <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      due        <= '0;
      next_ident <= tts_pkg::ID_ONE;
      proc_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      valid      <= valid_next;
      due        <= due_next;
      proc_valid <= cmd.rd_en;
      if (cmd.create && free_any) begin
        next_ident <= (next_ident == tts_pkg::ID_ALL_ONES) ? tts_pkg::ID_ONE
                                                           : next_ident + tts_pkg::ID_ONE;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item arguments and scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      arg_delay <= delay_ms[tts_pkg::MS_W-1] ? '0 : delay_ms[tts_pkg::ID_W-1:0];
      arg_rep   <= repeating;
      arg_id    <= timer_id;
      aid       <= '0;
    end else if (cmd.create && free_any) begin
      aid <= next_ident;
    end

    if (cmd.first && cmd.mode != tts_pkg::MODE_SELECT) begin
      least <= tts_pkg::ID_ALL_ONES;
      any   <= 1'b0;
    end else if (proc_valid && cmd.mode != tts_pkg::MODE_SELECT && keep) begin
      any <= 1'b1;
      if (eff_rem < least) least <= eff_rem;
    end

    if (cmd.first && cmd.mode == tts_pkg::MODE_SELECT) begin
      found <= 1'b0;
    end else if (proc_valid && cmd.mode == tts_pkg::MODE_SELECT && select_hit) begin
      found     <= 1'b1;
      best      <= rd_data.ident;
      best_slot <= proc_addr;
    end

    if (cmd.load) begin
      assigned_id <= aid;
      fired       <= sel_found;
      fired_id    <= sel_found ? best : '0;
      last        <= status.last;
      ms_to_next  <= any ? {1'b0, least} : '1;
      any_active  <= any;
    end
  end

endmodule

### rtl/core/timer_table_scheduler.sv
// Top level of the timer table scheduler.
// Table of up to SLOTS software timers with three kinds of input transaction:
// create (action 0) arms a timer with delay_ms (negative clamps to zero) and
// the repeating flag and returns a fresh nonzero id in assigned_id, or 0 when
// every slot is busy; clear (action 1) drops every timer whose id equals
// timer_id and ignores unknown ids; tick (action 2) marks one elapsed
// millisecond. Ids count up from 1 and wrap back to 1, never using 0. On a
// tick every held timer counts down (stopping at zero), and each timer that
// reaches zero fires: one result transaction per fired timer, in ascending
// id order (equal ids in slot order), with last set on the final one. A
// periodic timer reloads its interval, a one-shot timer frees its slot. A
// tick with nothing due, and every create or clear, returns exactly one
// result with last set. Every result carries ms_to_next (least remaining
// count after the item, -1 when the table is empty) and any_active.
// Timing: the slot fields sit in a table with one read and one write port
// and are read one slot per cycle through a registered read port. A create
// first writes the new slot in a state of its own; then every item makes
// one pass over the table; a clear, a create or a tick without expiries
// loads its result at the end of it. A tick that fires timers follows its pass
// with one ascending-id search pass per fired id, each ending in a result
// load, and the next item is taken after the final load. A stall on the
// result side holds the sequencer in place; in_stall is low only while the
// sequencer is idle, and a new item is taken even while the last result
// still waits in the output register.
module timer_table_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic signed [tts_pkg::MS_W-1:0] delay_ms,
  input  logic                            repeating,
  input  logic [tts_pkg::ID_W-1:0]        timer_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tts_pkg::ID_W-1:0]        assigned_id,
  output logic                            fired,
  output logic [tts_pkg::ID_W-1:0]        fired_id,
  output logic                            last,
  output logic signed [tts_pkg::MS_W-1:0] ms_to_next,
  output logic                            any_active
);

  // Slot index width, and a scan counter that can also hold SLOTS itself
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  tts_pkg::cmd_t    cmd;
  tts_pkg::status_t status;
  logic [SW-1:0]    rd_addr;

  // Sequencer: decode the transaction, walk the table, pace the results
  tts_ctrl #(
    .SLOTS (SLOTS),
    .SW    (SW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // Datapath: slot table, flags, min and id search, result register
  tts_datapath #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .delay_ms    (delay_ms),
    .repeating   (repeating),
    .timer_id    (timer_id),
    .out_stall   (out_stall),
    .status      (status),
    .out_valid   (out_valid),
    .assigned_id (assigned_id),
    .fired       (fired),
    .fired_id    (fired_id),
    .last        (last),
    .ms_to_next  (ms_to_next),
    .any_active  (any_active)
  );

endmodule

### rtl/core/tts_checker.sv
// Port-level checks of the timer table scheduler and their bind.
`include "timer_table_scheduler_macros.svh"

module tts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [tts_pkg::ID_W-1:0]        assigned_id,
  input logic                            fired,
  input logic [tts_pkg::ID_W-1:0]        fired_id,
  input logic                            last,
  input logic signed [tts_pkg::MS_W-1:0] ms_to_next,
  input logic                            any_active
);

  `TTS_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(fired_id))
  `TTS_ASSERT_IMPL(a_idle_id_zero, out_valid && !fired, fired_id == '0)
  `TTS_ASSERT_IMPL(a_empty_code, out_valid, any_active != (ms_to_next == '1))
  `TTS_ASSERT_IMPL(a_create_alone, out_valid && (assigned_id != '0), last && !fired)

endmodule

bind timer_table_scheduler tts_checker u_tts_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .assigned_id (assigned_id),
  .fired       (fired),
  .fired_id    (fired_id),
  .last        (last),
  .ms_to_next  (ms_to_next),
  .any_active  (any_active)
);
